FILE: rtl/core/bsp_point_leaf_locator_core_macros.svh
// assertion helpers for the locator core
`ifndef BSP_POINT_LEAF_LOCATOR_CORE_MACROS_SVH
`define BSP_POINT_LEAF_LOCATOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF

`define BPL_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bsp core assertion failed");

`define BPL_ASSERT_NEVER(label, clk, rst, cond) \
   `BPL_ASSERT(label, clk, rst, !(cond))

`else

`define BPL_ASSERT(label, clk, rst, prop)

`define BPL_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

FILE: rtl/core/bsp_pll_pkg.sv
package bsp_pll_pkg;

   localparam int NODE_COUNT  = 4096;
   localparam int PLANE_COUNT = 8192;
   localparam int NODE_AW     = $clog2(NODE_COUNT);
   localparam int PLANE_AW    = $clog2(PLANE_COUNT);

   localparam int TYPE_W  = 2;
   localparam int IDX_W   = 13;
   localparam int NRM_W   = 16;
   localparam int OFF_W   = 32;
   localparam int PT_W    = 32;
   localparam int CHILD_W = 13;
   localparam int AT_W    = CHILD_W - 1;
   localparam int LEAF_W  = 12;
   localparam int STEP_W  = 13;
   localparam int FRAC_W  = 14;
   localparam int PROD_W  = PT_W + NRM_W;
   localparam int DIST_W  = PROD_W + 4;

   localparam int NODE_W  = IDX_W + 2 * CHILD_W;
   localparam int PLANE_W = 3 * NRM_W + OFF_W;

   localparam logic [TYPE_W-1:0] REQ_PLANE = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_NODE  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd2;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_LOOP = 1'b1;

   localparam logic [STEP_W-1:0] STEP_RESET = 13'd4096;

   localparam logic [1:0] LANE_X = 2'd0;
   localparam logic [1:0] LANE_Y = 2'd1;
   localparam logic [1:0] LANE_Z = 2'd2;

   typedef struct packed {
      logic       load;
      logic       mul;
      logic [1:0] lane;
      logic       acc_prod;
   } dist_ctrl_type;

endpackage

FILE: rtl/core/bsp_pll_ram.sv
module bsp_pll_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/bsp_pll_dist.sv
module bsp_pll_dist
   import bsp_pll_pkg::*;
(
   input  logic                    clock,
   input  dist_ctrl_type           ctrl,
   input  logic signed [PT_W-1:0]  point_x,
   input  logic signed [PT_W-1:0]  point_y,
   input  logic signed [PT_W-1:0]  point_z,
   input  logic [PLANE_W-1:0]      plane,
   input  logic                    plane_ok,
   output logic                    positive
);

   logic signed [NRM_W-1:0]  nrm_sel;
   logic signed [PT_W-1:0]   pt_sel;
   logic signed [OFF_W-1:0]  off;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [DIST_W-1:0] acc_in;
   logic signed [DIST_W-1:0] acc_ff;
   logic signed [DIST_W-1:0] dist_sum;

   // plane word is {nx, ny, nz, offset}; a plane slot out of range acts as zero
   always_comb begin
      case (ctrl.lane)
         LANE_X: begin
            pt_sel  = point_x;
            nrm_sel = signed'(plane[PLANE_W-1 -: NRM_W]);
         end
         LANE_Y: begin
            pt_sel  = point_y;
            nrm_sel = signed'(plane[PLANE_W-1-NRM_W -: NRM_W]);
         end
         LANE_Z: begin
            pt_sel  = point_z;
            nrm_sel = signed'(plane[OFF_W +: NRM_W]);
         end
         default: begin
            pt_sel  = '0;
            nrm_sel = '0;
         end
      endcase
      if (!plane_ok) begin
         nrm_sel = '0;
      end
      off = plane_ok ? signed'(plane[OFF_W-1:0]) : '0;
   end

   assign prod_in = pt_sel * nrm_sel;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.load) begin
         acc_in = -(DIST_W'(off) <<< FRAC_W);
      end else if (ctrl.acc_prod) begin
         acc_in = acc_ff + DIST_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   assign dist_sum = acc_ff + DIST_W'(prod_ff);
   assign positive = !dist_sum[DIST_W-1] && (dist_sum != '0);

endmodule

FILE: rtl/core/bsp_point_leaf_locator_core.sv
// Point locator for a binary space partition tree. Plane and node write items
// are accepted and then answered with a result item. A query visits n nodes,
// and each visit is one node memory read, one dependent plane memory read,
// three passes through the single 32x16 multiplier with its accumulator, and
// one decide step. req_stall stays high from acceptance until the result item
// is taken. max_steps may only be written while no item is in flight.
`include "bsp_point_leaf_locator_core_macros.svh"

module bsp_point_leaf_locator_core
   import bsp_pll_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [TYPE_W-1:0]         req_type,
   input  logic [IDX_W-1:0]          req_entry_index,
   input  logic signed [NRM_W-1:0]   req_normal_x,
   input  logic signed [NRM_W-1:0]   req_normal_y,
   input  logic signed [NRM_W-1:0]   req_normal_z,
   input  logic signed [OFF_W-1:0]   req_plane_offset,
   input  logic [IDX_W-1:0]          req_plane_ref,
   input  logic signed [CHILD_W-1:0] req_child_front,
   input  logic signed [CHILD_W-1:0] req_child_back,
   input  logic signed [PT_W-1:0]    req_point_x,
   input  logic signed [PT_W-1:0]    req_point_y,
   input  logic signed [PT_W-1:0]    req_point_z,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [LEAF_W-1:0]         rsp_leaf_index,
   output logic                      rsp_status,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [STEP_W-1:0]         csr_max_steps
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_NODE   = 3'd1;
   localparam logic [2:0] S_PLANE  = 3'd2;
   localparam logic [2:0] S_MUL    = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   logic [2:0]               state_ff, state_in;
   logic [STEP_W-1:0]        max_steps_ff;
   logic signed [PT_W-1:0]   pt_x_ff, pt_x_in;
   logic signed [PT_W-1:0]   pt_y_ff, pt_y_in;
   logic signed [PT_W-1:0]   pt_z_ff, pt_z_in;
   logic [AT_W-1:0]          at_ff, at_in;
   logic [STEP_W-1:0]        steps_ff, steps_in;
   logic signed [CHILD_W-1:0] front_ff, front_in;
   logic signed [CHILD_W-1:0] back_ff, back_in;
   logic                     node_ok_ff, node_ok_in;
   logic                     plane_ok_ff, plane_ok_in;
   logic [1:0]               cnt_ff, cnt_in;
   logic [LEAF_W-1:0]        leaf_ff, leaf_in;
   logic                     status_ff, status_in;

   logic                     req_accept;
   logic [STEP_W-1:0]        step_limit;
   logic [STEP_W-1:0]        steps_next;
   logic signed [CHILD_W-1:0] next_child;
   logic [IDX_W-1:0]         split;

   logic                     plane_wr_en, node_wr_en;
   logic                     plane_rd_en, node_rd_en;
   logic [PLANE_W-1:0]       plane_q;
   logic [NODE_W-1:0]        node_q;
   dist_ctrl_type            dist_ctrl;
   logic                     positive;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = (state_ff == S_RESP);
   assign csr_ready  = 1'b1;
   assign rsp_leaf_index = leaf_ff;
   assign rsp_status     = status_ff;

   assign step_limit = (max_steps_ff == '0) ? STEP_W'(1) : max_steps_ff;
   assign steps_next = steps_ff + 1'b1;
   assign next_child = positive ? front_ff : back_ff;
   assign split      = node_ok_ff ? node_q[NODE_W-1 -: IDX_W] : '0;

   assign plane_wr_en = req_accept && (req_type == REQ_PLANE)
                        && (32'(req_entry_index) < PLANE_COUNT);
   assign node_wr_en  = req_accept && (req_type == REQ_NODE)
                        && (32'(req_entry_index) < NODE_COUNT);
   assign node_rd_en  = (state_ff == S_NODE);
   assign plane_rd_en = (state_ff == S_PLANE);

   always_comb begin
      state_in    = state_ff;
      pt_x_in     = pt_x_ff;
      pt_y_in     = pt_y_ff;
      pt_z_in     = pt_z_ff;
      at_in       = at_ff;
      steps_in    = steps_ff;
      front_in    = front_ff;
      back_in     = back_ff;
      node_ok_in  = node_ok_ff;
      plane_ok_in = plane_ok_ff;
      cnt_in      = cnt_ff;
      leaf_in     = leaf_ff;
      status_in   = status_ff;
      dist_ctrl   = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               leaf_in   = '0;
               status_in = STATUS_DONE;
               if (req_type == REQ_QUERY) begin
                  pt_x_in  = req_point_x;
                  pt_y_in  = req_point_y;
                  pt_z_in  = req_point_z;
                  at_in    = '0;
                  steps_in = '0;
                  state_in = S_NODE;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_NODE: begin
            node_ok_in = (32'(at_ff) < NODE_COUNT);
            state_in   = S_PLANE;
         end
         S_PLANE: begin
            // node slot out of range reads as plane 0 with both children 0
            front_in    = node_ok_ff ? signed'(node_q[2*CHILD_W-1 -: CHILD_W]) : '0;
            back_in     = node_ok_ff ? signed'(node_q[CHILD_W-1:0]) : '0;
            plane_ok_in = (32'(split) < PLANE_COUNT);
            cnt_in      = '0;
            state_in    = S_MUL;
         end
         S_MUL: begin
            dist_ctrl.mul      = 1'b1;
            dist_ctrl.lane     = cnt_ff;
            dist_ctrl.load     = (cnt_ff == LANE_X);
            dist_ctrl.acc_prod = (cnt_ff != LANE_X);
            cnt_in             = cnt_ff + 1'b1;
            if (cnt_ff == LANE_Z) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (next_child[CHILD_W-1]) begin
               // leaf code is -(leaf+1), i.e. the bitwise complement
               leaf_in   = ~next_child[LEAF_W-1:0];
               status_in = STATUS_DONE;
               state_in  = S_RESP;
            end else if (steps_next >= step_limit) begin
               leaf_in   = '0;
               status_in = STATUS_LOOP;
               state_in  = S_RESP;
            end else begin
               at_in    = next_child[AT_W-1:0];
               steps_in = steps_next;
               state_in = S_NODE;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_steps_ff <= STEP_RESET;
         steps_ff     <= '0;
      end else begin
         state_ff <= state_in;
         steps_ff <= steps_in;
         if (csr_valid && csr_ready) begin
            max_steps_ff <= csr_max_steps;
         end
      end
   end

   always_ff @(posedge clock) begin
      pt_x_ff     <= pt_x_in;
      pt_y_ff     <= pt_y_in;
      pt_z_ff     <= pt_z_in;
      at_ff       <= at_in;
      front_ff    <= front_in;
      back_ff     <= back_in;
      node_ok_ff  <= node_ok_in;
      plane_ok_ff <= plane_ok_in;
      cnt_ff      <= cnt_in;
      leaf_ff     <= leaf_in;
      status_ff   <= status_in;
   end

   bsp_pll_ram #(
      .WIDTH (PLANE_W),
      .DEPTH (PLANE_COUNT)
   ) u_plane_ram (
      .clock   (clock),
      .wr_en   (plane_wr_en),
      .wr_addr (PLANE_AW'(req_entry_index)),
      .wr_data ({req_normal_x, req_normal_y, req_normal_z, req_plane_offset}),
      .rd_en   (plane_rd_en),
      .rd_addr (PLANE_AW'(split)),
      .rd_data (plane_q)
   );

   bsp_pll_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODE_COUNT)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (NODE_AW'(req_entry_index)),
      .wr_data ({req_plane_ref, req_child_front, req_child_back}),
      .rd_en   (node_rd_en),
      .rd_addr (NODE_AW'(at_ff)),
      .rd_data (node_q)
   );

   bsp_pll_dist u_dist (
      .clock    (clock),
      .ctrl     (dist_ctrl),
      .point_x  (pt_x_ff),
      .point_y  (pt_y_ff),
      .point_z  (pt_z_ff),
      .plane    (plane_q),
      .plane_ok (plane_ok_ff),
      .positive (positive)
   );

   `BPL_ASSERT_NEVER(a_rsp_blocks_req, clock, reset, rsp_valid && !req_stall)
   `BPL_ASSERT(a_loop_leaf_zero, clock, reset,
      (rsp_valid && rsp_status == STATUS_LOOP) |-> (rsp_leaf_index == '0))
   `BPL_ASSERT(a_steps_below_limit, clock, reset,
      (state_ff == S_DECIDE) |-> (steps_ff < step_limit))
   `BPL_ASSERT(a_query_starts_walk, clock, reset,
      (req_accept && req_type == REQ_QUERY) |=> (state_ff == S_NODE))

endmodule
